@@ rtl/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg: sorted priority queue shared definitions
// Widths, status codes and controller/datapath interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  localparam int QUEUE_DEPTH   = 16;
  localparam int PRIORITY_BITS = 32;
  localparam int TAG_BITS      = 16;
  localparam int CNT_BITS      = $clog2(QUEUE_DEPTH + 1);
  localparam int OCC_BITS      = 5;
  localparam int STATUS_BITS   = 2;

  localparam logic [STATUS_BITS-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_BITS-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_BITS-1:0] STAT_EMPTY = 2'd2;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  // command from controller to datapath
  typedef struct packed {
    logic acc;  // word accepted this cycle
    logic ins;  // insert permitted
    logic rem;  // remove permitted
  } spq_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
  } spq_stat_t;

endpackage

`default_nettype wire

@@ rtl/sorted_priority_queue_core.sv @@
// ----------------------------------------------------------------------------
// sorted_priority_queue_core: bounded sorted min-priority queue
// Holds up to QUEUE_DEPTH entries in ascending priority order; equal
// priorities leave in arrival order.
//
// Input channel: a word (in_func, in_priority_in, in_tag_in) is taken on
// a rising edge with start high and busy low. in_func selects insert or
// remove of the lowest-priority entry. busy stays low: one word per cycle.
// Result channel: exactly one result per word, shown for one cycle with
// out_strobe high, in the cycle after the word is taken. The
// result carries the removed entry (zero otherwise), out_entry_valid, the
// occupancy after the operation and out_status (ok, full, empty refusal).
// The shifting register store sustains that rate: every slot compares
// and shifts in parallel, so insert and remove never hold the flow.
// The receiver cannot stall; results must be taken as shown.
// Reset (rst_n low, synchronous) empties the queue and clears the strobe.
// Stored entries need no reset; only occupied slots are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue_core
  import spq_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic                     in_func,
  input  wire logic [PRIORITY_BITS-1:0] in_priority_in,
  input  wire logic [TAG_BITS-1:0]      in_tag_in,
  output logic                          out_strobe,
  output logic [PRIORITY_BITS-1:0]      out_priority_out,
  output logic [TAG_BITS-1:0]           out_tag_out,
  output logic                          out_entry_valid,
  output logic [OCC_BITS-1:0]           out_occupancy,
  output logic [STATUS_BITS-1:0]        out_status
);

  spq_cmd_t            cmd;
  spq_stat_t           stat;
  logic [CNT_BITS-1:0] count;
  logic                start_acc;

  assign start_acc = start && !busy;

  spq_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start_acc),
    .func        (in_func),
    .stat        (stat),
    .cmd         (cmd),
    .busy        (busy),
    .strobe      (out_strobe),
    .entry_valid (out_entry_valid),
    .status      (out_status)
  );

  spq_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .prio_in  (in_priority_in),
    .tag_in   (in_tag_in),
    .stat     (stat),
    .prio_out (out_priority_out),
    .tag_out  (out_tag_out),
    .count    (count)
  );

  assign out_occupancy = OCC_BITS'(count);

endmodule

`default_nettype wire

@@ rtl/spq_ctrl.sv @@
// ----------------------------------------------------------------------------
// spq_ctrl: sorted priority queue controller
// Decodes each word, refuses full inserts and empty removes, drives strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_ctrl
  import spq_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic                   func,
  input  wire spq_stat_t              stat,
  output spq_cmd_t                    cmd,
  output logic                        busy,
  output logic                        strobe,
  output logic                        entry_valid,
  output logic [STATUS_BITS-1:0]      status
);

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_RESULT
  } state_t;

  state_t                 state_r, state_nxt;
  logic                   strobe_r, strobe_nxt;
  logic                   valid_r, valid_nxt;
  logic [STATUS_BITS-1:0] status_r, status_nxt;

  // the store never holds the flow, so a new word is always taken
  assign busy = 1'b0;

  always_comb begin
    cmd.acc = start;
    cmd.ins = start && (func == FUNC_INSERT) && !stat.full;
    cmd.rem = start && (func == FUNC_REMOVE) && !stat.empty;
  end

  always_comb begin
    state_nxt  = state_r;
    strobe_nxt = 1'b0;
    valid_nxt  = 1'b0;
    status_nxt = STAT_OK;
    case (state_r)
      ST_IDLE, ST_RESULT: begin
        if (start) begin
          state_nxt  = ST_RESULT;
          strobe_nxt = 1'b1;
          valid_nxt  = cmd.rem;
          if ((func == FUNC_INSERT) && stat.full) begin
            status_nxt = STAT_FULL;
          end else if ((func == FUNC_REMOVE) && stat.empty) begin
            status_nxt = STAT_EMPTY;
          end
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      strobe_r <= 1'b0;
      valid_r  <= 1'b0;
      status_r <= STAT_OK;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
      valid_r  <= valid_nxt;
      status_r <= status_nxt;
    end
  end

  assign strobe      = strobe_r;
  assign entry_valid = valid_r;
  assign status      = status_r;

endmodule

`default_nettype wire

@@ rtl/spq_dpath.sv @@
// ----------------------------------------------------------------------------
// spq_dpath: sorted priority queue datapath
// Shifting sorted register store, per-slot compare, count and result words.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_dpath
  import spq_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire spq_cmd_t                 cmd,
  input  wire logic [PRIORITY_BITS-1:0] prio_in,
  input  wire logic [TAG_BITS-1:0]      tag_in,
  output spq_stat_t                     stat,
  output logic [PRIORITY_BITS-1:0]      prio_out,
  output logic [TAG_BITS-1:0]           tag_out,
  output logic [CNT_BITS-1:0]           count
);

  logic [PRIORITY_BITS-1:0] prio_r   [QUEUE_DEPTH];
  logic [TAG_BITS-1:0]      tag_r    [QUEUE_DEPTH];
  logic [PRIORITY_BITS-1:0] prio_nxt [QUEUE_DEPTH];
  logic [TAG_BITS-1:0]      tag_nxt  [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]   le;
  logic [CNT_BITS-1:0]      count_r, count_nxt;
  logic [PRIORITY_BITS-1:0] prio_out_r;
  logic [TAG_BITS-1:0]      tag_out_r;

  assign stat.full  = (count_r == CNT_BITS'(QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);

  // le is a thermometer: stored slots at or below the new priority
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      le[i] = (CNT_BITS'(i) < count_r) && (prio_r[i] <= prio_in);
    end
  end

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      prio_nxt[i] = prio_r[i];
      tag_nxt[i]  = tag_r[i];
      if (cmd.ins) begin
        if (le[i]) begin
          prio_nxt[i] = prio_r[i];
          tag_nxt[i]  = tag_r[i];
        end else if ((i == 0) || le[(i == 0) ? 0 : i - 1]) begin
          prio_nxt[i] = prio_in;
          tag_nxt[i]  = tag_in;
        end else begin
          prio_nxt[i] = prio_r[(i == 0) ? 0 : i - 1];
          tag_nxt[i]  = tag_r[(i == 0) ? 0 : i - 1];
        end
      end else if (cmd.rem && (i < QUEUE_DEPTH - 1)) begin
        prio_nxt[i] = prio_r[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
        tag_nxt[i]  = tag_r[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.ins) begin
      count_nxt = count_r + CNT_BITS'(1);
    end else if (cmd.rem) begin
      count_nxt = count_r - CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      prio_r[i] <= prio_nxt[i];
      tag_r[i]  <= tag_nxt[i];
    end
    if (cmd.acc) begin
      prio_out_r <= cmd.rem ? prio_r[0] : '0;
      tag_out_r  <= cmd.rem ? tag_r[0]  : '0;
    end
  end

  assign prio_out = prio_out_r;
  assign tag_out  = tag_out_r;
  assign count    = count_r;

endmodule

`default_nettype wire

@@ rtl/spq_checker.sv @@
// ----------------------------------------------------------------------------
// spq_checker: port-level checks for the sorted priority queue
// Result timing and consistency of flags, payload and occupancy.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_checker
  import spq_pkg::*;
(
  input wire logic                     clk,
  input wire logic                     rst_n,
  input wire logic                     start,
  input wire logic                     busy,
  input wire logic                     out_strobe,
  input wire logic [PRIORITY_BITS-1:0] out_priority_out,
  input wire logic [TAG_BITS-1:0]      out_tag_out,
  input wire logic                     out_entry_valid,
  input wire logic [OCC_BITS-1:0]      out_occupancy,
  input wire logic [STATUS_BITS-1:0]   out_status
);

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_strobe)
    else $error("accepted word gave no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |=> !out_strobe)
    else $error("result without accepted word");

  a_valid_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_entry_valid) |-> (out_status == STAT_OK))
    else $error("removed entry with refusal status");

  a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_entry_valid) |->
      (out_priority_out == '0 && out_tag_out == '0))
    else $error("non-removal result carries payload");

  a_refusal_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status == STAT_EMPTY) |-> (out_occupancy == '0))
    else $error("empty refusal with non-zero occupancy");

endmodule

bind sorted_priority_queue_core spq_checker u_spq_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_strobe       (out_strobe),
  .out_priority_out (out_priority_out),
  .out_tag_out      (out_tag_out),
  .out_entry_valid  (out_entry_valid),
  .out_occupancy    (out_occupancy),
  .out_status       (out_status)
);

`default_nettype wire

@@ tb/sv/spq_scoreboard_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_scoreboard_pkg: sorted priority queue scoreboard
// Keeps its own sorted store, works out the result of each accepted word
// and compares every result shown by the block against the oldest one due.
// ----------------------------------------------------------------------------
package spq_scoreboard_pkg;
  import spq_pkg::*;

  typedef struct packed {
    logic [PRIORITY_BITS-1:0] prio;
    logic [TAG_BITS-1:0]      tag;
    logic                     valid;
    logic [OCC_BITS-1:0]      occ;
    logic [STATUS_BITS-1:0]   status;
  } queue_result_t;

  class queue_scoreboard;
    logic [PRIORITY_BITS-1:0] slot_prio [QUEUE_DEPTH];
    logic [TAG_BITS-1:0]      slot_tag  [QUEUE_DEPTH];
    int                       held;
    queue_result_t            results_due[$];
    int                       errors;
    int                       words_taken;
    int                       entries_out;
    int                       full_refusals;
    int                       empty_refusals;

    function new();
      held           = 0;
      errors         = 0;
      words_taken    = 0;
      entries_out    = 0;
      full_refusals  = 0;
      empty_refusals = 0;
    endfunction

    function int pending();
      return results_due.size();
    endfunction

    // sorted insert after equals, or pop from the front
    function void note_word(logic func, logic [PRIORITY_BITS-1:0] prio,
                            logic [TAG_BITS-1:0] tag);
      queue_result_t r;
      int            pos;
      r = '0;
      r.status = STAT_OK;
      words_taken++;
      if (func == FUNC_INSERT) begin
        if (held >= QUEUE_DEPTH) begin
          r.status = STAT_FULL;
          full_refusals++;
        end else begin
          pos = 0;
          while (pos < held && slot_prio[pos] <= prio) pos++;
          for (int i = held; i > pos; i--) begin
            slot_prio[i] = slot_prio[i-1];
            slot_tag[i]  = slot_tag[i-1];
          end
          slot_prio[pos] = prio;
          slot_tag[pos]  = tag;
          held++;
        end
      end else begin
        if (held == 0) begin
          r.status = STAT_EMPTY;
          empty_refusals++;
        end else begin
          r.prio  = slot_prio[0];
          r.tag   = slot_tag[0];
          r.valid = 1'b1;
          for (int i = 1; i < held; i++) begin
            slot_prio[i-1] = slot_prio[i];
            slot_tag[i-1]  = slot_tag[i];
          end
          held--;
          entries_out++;
        end
      end
      r.occ = held[OCC_BITS-1:0];
      results_due.push_back(r);
    endfunction

    function void check_result(queue_result_t got);
      queue_result_t want;
      if (results_due.size() == 0) begin
        $display("%0t: result with nothing due: prio %0h tag %0h valid %0b occ %0d status %0d",
                 $time, got.prio, got.tag, got.valid, got.occ, got.status);
        errors++;
        return;
      end
      want = results_due.pop_front();
      if (got.prio !== want.prio) begin
        $display("%0t: priority mismatch: expected %0h actual %0h", $time, want.prio, got.prio);
        errors++;
      end
      if (got.tag !== want.tag) begin
        $display("%0t: tag mismatch: expected %0h actual %0h", $time, want.tag, got.tag);
        errors++;
      end
      if (got.valid !== want.valid) begin
        $display("%0t: entry_valid mismatch: expected %0b actual %0b",
                 $time, want.valid, got.valid);
        errors++;
      end
      if (got.occ !== want.occ) begin
        $display("%0t: occupancy mismatch: expected %0d actual %0d", $time, want.occ, got.occ);
        errors++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status mismatch: expected %0d actual %0d",
                 $time, want.status, got.status);
        errors++;
      end
    endfunction
  endclass

endpackage

@@ tb/sv/tb_sorted_priority_queue_core.sv @@
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue_core: sorted priority queue testbench
// Directed words cover the empty and full refusals, extreme priorities and
// tags and equal-priority ordering; random bursts biased to fill, drain or
// mix the queue follow, under several sender idling patterns.
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue_core;
  import spq_pkg::*;
  import spq_scoreboard_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int WORDS_PER_PHASE = 200;
  localparam int BURST_LEN       = 20;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic                     in_func = FUNC_INSERT;
  logic [PRIORITY_BITS-1:0] in_priority_in = '0;
  logic [TAG_BITS-1:0]      in_tag_in = '0;
  logic                     out_strobe;
  logic [PRIORITY_BITS-1:0] out_priority_out;
  logic [TAG_BITS-1:0]      out_tag_out;
  logic                     out_entry_valid;
  logic [OCC_BITS-1:0]      out_occupancy;
  logic [STATUS_BITS-1:0]   out_status;

  queue_scoreboard sb = new();
  queue_result_t   seen;
  int              cycle_count = 0;

  sorted_priority_queue_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_priority_in   (in_priority_in),
    .in_tag_in        (in_tag_in),
    .out_strobe       (out_strobe),
    .out_priority_out (out_priority_out),
    .out_tag_out      (out_tag_out),
    .out_entry_valid  (out_entry_valid),
    .out_occupancy    (out_occupancy),
    .out_status       (out_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_word(in_func, in_priority_in, in_tag_in);
      if (out_strobe) begin
        seen.prio   = out_priority_out;
        seen.tag    = out_tag_out;
        seen.valid  = out_entry_valid;
        seen.occ    = out_occupancy;
        seen.status = out_status;
        sb.check_result(seen);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_count, sb.pending());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_word(logic func, logic [PRIORITY_BITS-1:0] prio,
                           logic [TAG_BITS-1:0] tag);
    start          <= 1'b1;
    in_func        <= func;
    in_priority_in <= prio;
    in_tag_in      <= tag;
    do @(posedge clk); while (busy);
  endtask

  task automatic hold_off(int idle_pct);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic wait_results_in();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
  endtask

  function automatic logic [PRIORITY_BITS-1:0] pick_priority();
    int sel;
    sel = $urandom_range(99);
    if (sel < 40) return PRIORITY_BITS'($urandom_range(7));
    if (sel < 45) return '0;
    if (sel < 50) return '1;
    return PRIORITY_BITS'($urandom);
  endfunction

  initial begin
    int idle_pct;
    int insert_pct;
    logic func;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty refusal, extremes, equal priorities, fill to full
    send_word(FUNC_REMOVE, '0, '0);
    send_word(FUNC_INSERT, '1, '1);
    send_word(FUNC_INSERT, '0, '0);
    send_word(FUNC_INSERT, PRIORITY_BITS'(7), TAG_BITS'(16'h0A0A));
    send_word(FUNC_INSERT, PRIORITY_BITS'(7), TAG_BITS'(16'h0B0B));
    for (int i = 0; i < 12; i++) begin
      send_word(FUNC_INSERT, (i < 6) ? PRIORITY_BITS'(32'h1000) : PRIORITY_BITS'(32'hAAAA5555 + i),
                TAG_BITS'(16'h5500 + i));
    end
    send_word(FUNC_INSERT, PRIORITY_BITS'(1), TAG_BITS'(1));
    repeat (4) send_word(FUNC_REMOVE, PRIORITY_BITS'($urandom), TAG_BITS'($urandom));

    // random bursts: no idling, sender idle 77 in 100, then 38 in 100
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 0 : (phase == 1) ? 77 : 38;
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        if (n % BURST_LEN == 0) begin
          case ($urandom_range(2))
            0: begin
              insert_pct = 80;
            end
            1: begin
              insert_pct = 20;
            end
            default: begin
              insert_pct = 50;
            end
          endcase
        end
        if (phase == 1 && n == WORDS_PER_PHASE / 2) wait_results_in();
        func = ($urandom_range(99) < insert_pct) ? FUNC_INSERT : FUNC_REMOVE;
        send_word(func, pick_priority(), TAG_BITS'($urandom_range(16'hFFFF)));
        hold_off(idle_pct);
      end
    end

    wait_results_in();
    repeat (4) @(posedge clk);
    $display("Ran %0d words: %0d entries removed, %0d inserts refused full, %0d removes refused empty",
             sb.words_taken, sb.entries_out, sb.full_refusals, sb.empty_refusals);
    $display("Mismatches: %0d", sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
